@@ design/scv_pkg.sv @@
// ----------------------------------------------------------------------------
// scv_pkg
// Shared types and constants for the skew correction vector unit.
// ----------------------------------------------------------------------------
package scv_pkg;

   localparam int RATIO_FRAC_BITS = 24;
   localparam int SCALE_CAP_BITS  = 40;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_W      = 3;

   localparam logic [31:0] SKEW_THRESHOLD_RESET = 32'd168;
   localparam logic [0:0]  REG_SKEW_THRESHOLD   = 1'b0;

   typedef enum logic [1:0] {
      OP_INTERIOR   = 2'd0,
      OP_COUPLED    = 2'd1,
      OP_UNCOUPLED  = 2'd2
   } face_op_type;

   typedef struct packed {
      logic             compute;
      logic             interior;
      logic             last;
      logic [2:0][31:0] offset;
      logic [2:0][31:0] delta;
      logic [2:0][31:0] area;
   } face_item_type;

   typedef struct packed {
      logic        start;
      logic        sqrt_mode;
      logic [63:0] rem;
      logic [63:0] bits;
      logic [63:0] den;
      logic [5:0]  steps;
   } iter_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } iter_rsp_type;

endpackage

@@ design/skew_correction_vector_unit.sv @@
// ----------------------------------------------------------------------------
// skew_correction_vector_unit
// Per-face skew correction vector with running skew ratio maximum.
// Faces use the shared divide/root unit, one result bit per cycle, for up to
// six operations; uncoupled boundary faces do not use it.
// Faces are processed one at a time; a 2-entry queue takes faces meanwhile.
// Reset: synchronous; clears the maximum, queue and sequencer, threshold 168.
// ----------------------------------------------------------------------------
module skew_correction_vector_unit
   import scv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [287:0]          req_tdata,  // offset_x/y/z, delta_x/y/z, area_x/y/z
   input  logic [1:0]            req_tuser,  // op
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [127:0]          rsp_tdata,  // corr_x, corr_y, corr_z, max_ratio
   output logic [1:0]            rsp_tuser,  // divide_fault, mesh_skewed
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [31:0]   threshold_ff;
   logic          q_full;
   logic          q_empty;
   logic          q_push;
   logic          q_pop;
   face_item_type push_item;
   face_item_type pop_item;
   iter_req_type  iter_req;
   iter_rsp_type  iter_rsp;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_SKEW_THRESHOLD) ? threshold_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= SKEW_THRESHOLD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == REG_SKEW_THRESHOLD) begin
         threshold_ff <= csr_pwdata;
      end
   end

   scv_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   scv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .full      (q_full),
      .empty     (q_empty)
   );

   scv_iter u_iter (
      .clock (clock),
      .reset (reset),
      .req   (iter_req),
      .rsp   (iter_rsp)
   );

   scv_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_item         (pop_item),
      .q_pop          (q_pop),
      .skew_threshold (threshold_ff),
      .iter_req       (iter_req),
      .iter_rsp       (iter_rsp),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast)
   );

endmodule

@@ design/scv_front.sv @@
// ----------------------------------------------------------------------------
// scv_front
// Accepts face transactions, decodes the face kind and pushes work items.
// ----------------------------------------------------------------------------
module scv_front
   import scv_pkg::*;
(
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [287:0]  req_tdata,
   input  logic [1:0]    req_tuser,
   input  logic          req_tlast,
   input  logic          q_full,
   output logic          q_push,
   output face_item_type q_item
);

   always_comb begin
      req_tready       = !q_full;
      q_push           = req_tvalid && !q_full;
      q_item.last      = req_tlast;
      q_item.interior  = 1'b0;
      q_item.compute   = 1'b0;
      case (req_tuser)
         OP_INTERIOR: begin
            q_item.interior = 1'b1;
            q_item.compute  = 1'b1;
         end
         OP_COUPLED: begin
            q_item.compute  = 1'b1;
         end
         default: begin
            q_item.compute  = 1'b0;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         q_item.offset[i] = req_tdata[32*i +: 32];
         q_item.delta[i]  = req_tdata[96 + 32*i +: 32];
         q_item.area[i]   = req_tdata[192 + 32*i +: 32];
      end
   end

endmodule

@@ design/scv_queue.sv @@
// ----------------------------------------------------------------------------
// scv_queue
// Short FIFO of decoded face items between front and back.
// ----------------------------------------------------------------------------
module scv_queue
   import scv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  face_item_type push_item,
   input  logic          pop,
   output face_item_type pop_item,
   output logic          full,
   output logic          empty
);

   face_item_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]         wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]         rd_ptr_ff;
   logic [QUEUE_PTR_W:0]           count_ff;

   assign full     = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ design/scv_iter.sv @@
// ----------------------------------------------------------------------------
// scv_iter
// Shared iterative unit: restoring divide or integer square root,
// one result bit per cycle.
// ----------------------------------------------------------------------------
module scv_iter
   import scv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  iter_req_type req,
   output iter_rsp_type rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic        sqrt_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] rem_ff;
   logic [63:0] bits_ff;
   logic [63:0] den_ff;
   logic [63:0] q_ff;

   logic [63:0] rem_sh;
   logic [64:0] div_diff;
   logic [63:0] sq_t;
   logic        ge;
   logic [63:0] rem_in;
   logic [63:0] q_in;
   logic [63:0] bits_in;

   always_comb begin
      rem_sh   = {rem_ff[62:0], bits_ff[63]};
      div_diff = {1'b0, rem_sh} - {1'b0, den_ff};
      sq_t     = q_ff + bits_ff;
      if (sqrt_ff) begin
         ge      = (rem_ff >= sq_t);
         rem_in  = ge ? rem_ff - sq_t : rem_ff;
         q_in    = ge ? (q_ff >> 1) + bits_ff : q_ff >> 1;
         bits_in = bits_ff >> 2;
      end else begin
         ge      = !div_diff[64];
         rem_in  = ge ? div_diff[63:0] : rem_sh;
         q_in    = {q_ff[62:0], ge};
         bits_in = bits_ff << 1;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            sqrt_ff <= req.sqrt_mode;
            cnt_ff  <= req.steps;
            rem_ff  <= req.rem;
            bits_ff <= req.bits;
            den_ff  <= req.den;
            q_ff    <= '0;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            q_ff    <= q_in;
            bits_ff <= bits_in;
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

@@ design/scv_back.sv @@
// ----------------------------------------------------------------------------
// scv_back
// Sequencer: dot products, squares and scale products on one 32x32 multiplier,
// divides and roots on the shared iterative unit, running maximum and result register.
// ----------------------------------------------------------------------------
module scv_back
   import scv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  face_item_type q_item,
   output logic          q_pop,
   input  logic [31:0]   skew_threshold,
   output iter_req_type  iter_req,
   input  iter_rsp_type  iter_rsp,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [127:0]  rsp_tdata,
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DOT, ST_SQD, ST_SQDW, ST_PLO, ST_PHI, ST_PSUM, ST_DIV,
      ST_DIVW, ST_KSQ, ST_SQK, ST_SQKW, ST_RATW, ST_DONE
   } state_type;

   localparam logic [40:0] SCALE_CAP = 41'(64'd1 << SCALE_CAP_BITS);

   state_type        state_ff;
   face_item_type    item_ff;
   logic [3:0]       cnt_ff;
   logic [1:0]       idx_ff;
   logic signed [63:0] num_ff;
   logic signed [63:0] den_ff;
   logic [63:0]      sumsq_ff;
   logic [31:0]      nd_ff;
   logic [95:0]      p_ff;
   logic [2:0][31:0] k_ff;
   logic             fault_ff;
   logic [31:0]      max_ff;
   logic [63:0]      prod_ff;
   logic             neg_ff;
   logic [3:0]       tag_ff;
   logic             acc_ff;
   logic             out_valid_ff;
   logic [127:0]     out_data_ff;
   logic [1:0]       out_user_ff;
   logic             out_last_ff;

   logic [31:0]      mul_a;
   logic [31:0]      mul_b;
   logic             mul_neg;
   logic             mul_acc;
   logic [3:0]       mul_tag;
   logic [63:0]      num_mag;
   logic [63:0]      den_mag;
   logic [61:0]      term;
   logic             scale_neg;
   logic [31:0]      ratio;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? 32'(-v) : v;
   endfunction

   function automatic logic [31:0] corr_calc(input logic [31:0] o, input logic [40:0] q,
                                             input logic neg);
      logic signed [42:0] v;
      logic signed [42:0] qs;
      qs = $signed({2'b00, q});
      v  = neg ? $signed({{11{o[31]}}, o}) + qs : $signed({{11{o[31]}}, o}) - qs;
      if (v > 43'sh7FFFFFFF) begin
         corr_calc = 32'h7FFFFFFF;
      end else if (v < -43'sh80000000) begin
         corr_calc = 32'h80000000;
      end else begin
         corr_calc = v[31:0];
      end
   endfunction

   function automatic logic [1:0] sel3(input logic [3:0] c);
      case (c)
         4'd0, 4'd3, 4'd6: sel3 = 2'd0;
         4'd1, 4'd4, 4'd7: sel3 = 2'd1;
         default:          sel3 = 2'd2;
      endcase
   endfunction

   always_comb begin
      num_mag   = num_ff[63] ? 64'(-num_ff) : 64'(num_ff);
      den_mag   = den_ff[63] ? 64'(-den_ff) : 64'(den_ff);
      term      = prod_ff[63:2];
      scale_neg = num_ff[63] ^ item_ff.delta[idx_ff][31] ^ den_ff[63];
      mul_a     = '0;
      mul_b     = '0;
      mul_neg   = 1'b0;
      mul_acc   = 1'b0;
      mul_tag   = cnt_ff;
      case (state_ff)
         ST_DOT: begin
            mul_acc = (cnt_ff < 4'd9);
            if (cnt_ff < 4'd3) begin
               mul_a   = mag32(item_ff.area[sel3(cnt_ff)]);
               mul_b   = mag32(item_ff.offset[sel3(cnt_ff)]);
               mul_neg = item_ff.area[sel3(cnt_ff)][31] ^ item_ff.offset[sel3(cnt_ff)][31];
            end else if (cnt_ff < 4'd6) begin
               mul_a   = mag32(item_ff.area[sel3(cnt_ff)]);
               mul_b   = mag32(item_ff.delta[sel3(cnt_ff)]);
               mul_neg = item_ff.area[sel3(cnt_ff)][31] ^ item_ff.delta[sel3(cnt_ff)][31];
            end else begin
               mul_a   = mag32(item_ff.delta[sel3(cnt_ff)]);
               mul_b   = mul_a;
            end
         end
         ST_KSQ: begin
            mul_acc = (cnt_ff < 4'd3);
            mul_tag = cnt_ff + 4'd6;
            mul_a   = mag32(k_ff[sel3(cnt_ff)]);
            mul_b   = mul_a;
         end
         ST_PLO: begin
            mul_a = num_mag[31:0];
            mul_b = mag32(item_ff.delta[idx_ff]);
         end
         ST_PHI: begin
            mul_a = num_mag[63:32];
            mul_b = mag32(item_ff.delta[idx_ff]);
         end
         default: begin
            mul_acc = 1'b0;
         end
      endcase
   end

   always_comb begin
      iter_req       = '0;
      ratio          = iter_rsp.value[31:0];
      case (state_ff)
         ST_SQD: begin
            iter_req.start     = 1'b1;
            iter_req.sqrt_mode = 1'b1;
            iter_req.rem       = sumsq_ff;
            iter_req.bits      = 64'd1 << 62;
            iter_req.steps     = 6'd32;
         end
         ST_SQK: begin
            iter_req.start     = 1'b1;
            iter_req.sqrt_mode = 1'b1;
            iter_req.rem       = sumsq_ff;
            iter_req.bits      = 64'd1 << 62;
            iter_req.steps     = 6'd32;
         end
         ST_DIV: begin
            iter_req.start = ({9'd0, p_ff[95:41]} < den_mag);
            iter_req.rem   = {9'd0, p_ff[95:41]};
            iter_req.bits  = {p_ff[40:0], 23'd0};
            iter_req.den   = den_mag;
            iter_req.steps = 6'd41;
         end
         ST_SQKW: begin
            iter_req.start = iter_rsp.done && (iter_rsp.value[31:8] < nd_ff);
            iter_req.rem   = {40'd0, iter_rsp.value[31:8]};
            iter_req.bits  = {iter_rsp.value[7:0], 56'd0};
            iter_req.den   = {32'd0, nd_ff};
            iter_req.steps = 6'd32;
         end
         default: begin
            iter_req.start = 1'b0;
         end
      endcase
   end

   assign q_pop      = (state_ff == ST_IDLE) && !q_empty;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      neg_ff  <= mul_neg;
      tag_ff  <= mul_tag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_ff       <= '0;
         out_valid_ff <= 1'b0;
         acc_ff       <= 1'b0;
      end else begin
         acc_ff <= mul_acc;
         if (out_valid_ff && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (acc_ff) begin
            if (tag_ff < 4'd3) begin
               num_ff <= num_ff + (neg_ff ? -$signed({2'b00, term}) : $signed({2'b00, term}));
            end else if (tag_ff < 4'd6) begin
               den_ff <= den_ff + (neg_ff ? -$signed({2'b00, term}) : $signed({2'b00, term}));
            end else begin
               sumsq_ff <= sumsq_ff + prod_ff;
            end
         end
         case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  item_ff  <= q_item;
                  k_ff     <= '0;
                  fault_ff <= 1'b0;
                  num_ff   <= '0;
                  den_ff   <= '0;
                  sumsq_ff <= '0;
                  cnt_ff   <= '0;
                  state_ff <= q_item.compute ? ST_DOT : ST_DONE;
               end
            end
            ST_DOT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 4'd9) begin
                  state_ff <= ST_SQD;
               end
            end
            ST_SQD: begin
               state_ff <= ST_SQDW;
            end
            ST_SQDW: begin
               if (iter_rsp.done) begin
                  nd_ff  <= iter_rsp.value[31:0];
                  idx_ff <= '0;
                  if (den_ff == '0 || iter_rsp.value == '0) begin
                     fault_ff <= 1'b1;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_PLO;
                  end
               end
            end
            ST_PLO: begin
               state_ff <= ST_PHI;
            end
            ST_PHI: begin
               p_ff     <= {32'd0, prod_ff};
               state_ff <= ST_PSUM;
            end
            ST_PSUM: begin
               p_ff     <= {prod_ff, 32'd0} + p_ff;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (!iter_req.start) begin
                  k_ff[idx_ff] <= corr_calc(item_ff.offset[idx_ff], SCALE_CAP, scale_neg);
                  idx_ff       <= idx_ff + 1'b1;
                  cnt_ff       <= '0;
                  sumsq_ff     <= '0;
                  if (idx_ff == 2'd2) begin
                     state_ff <= item_ff.interior ? ST_KSQ : ST_DONE;
                  end else begin
                     state_ff <= ST_PLO;
                  end
               end else begin
                  state_ff <= ST_DIVW;
               end
            end
            ST_DIVW: begin
               if (iter_rsp.done) begin
                  k_ff[idx_ff] <= corr_calc(item_ff.offset[idx_ff],
                                            (iter_rsp.value[40:0] > SCALE_CAP) ?
                                            SCALE_CAP : iter_rsp.value[40:0], scale_neg);
                  idx_ff       <= idx_ff + 1'b1;
                  cnt_ff       <= '0;
                  sumsq_ff     <= '0;
                  if (idx_ff == 2'd2) begin
                     state_ff <= item_ff.interior ? ST_KSQ : ST_DONE;
                  end else begin
                     state_ff <= ST_PLO;
                  end
               end
            end
            ST_KSQ: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 4'd3) begin
                  state_ff <= ST_SQK;
               end
            end
            ST_SQK: begin
               state_ff <= ST_SQKW;
            end
            ST_SQKW: begin
               if (iter_rsp.done) begin
                  if (!iter_req.start) begin
                     max_ff   <= 32'hFFFFFFFF;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_RATW;
                  end
               end
            end
            ST_RATW: begin
               if (iter_rsp.done) begin
                  if (ratio > max_ff) begin
                     max_ff <= ratio;
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!out_valid_ff || rsp_tready) begin
                  out_valid_ff <= 1'b1;
                  out_data_ff  <= {max_ff, k_ff[2], k_ff[1], k_ff[0]};
                  out_user_ff  <= {item_ff.last && (max_ff >= skew_threshold), fault_ff};
                  out_last_ff  <= item_ff.last;
                  if (item_ff.last) begin
                     max_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ design/scv_checker.sv @@
// ----------------------------------------------------------------------------
// scv_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module scv_checker
   import scv_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result transaction dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result data changed while stalled");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[95:0] == '0)
      else $error("faulted face carries nonzero correction");

   a_skew_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("skew flag outside last face");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind skew_correction_vector_unit scv_checker u_scv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/sv/skew_correction_vector_unit_test.sv @@
// ----------------------------------------------------------------------------
// skew_correction_vector_unit_test
// Streams mesh faces through the skew correction unit and checks every
// result against a bit-exact predictor of the correction vector, the
// running ratio maximum and the end-of-pass skew flag. Runs several
// threshold settings with random idling on both stream sides.
// ----------------------------------------------------------------------------
module skew_correction_vector_unit_test;
   import scv_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int NUM_PHASES = 6;
   localparam int ITEMS_PER_PHASE = 242;

   typedef struct packed {
      logic [1:0]       op;
      logic             last;
      logic [2:0][31:0] area;
      logic [2:0][31:0] delta;
      logic [2:0][31:0] offset;
   } face_type;

   typedef struct packed {
      logic [31:0] corr_x;
      logic [31:0] corr_y;
      logic [31:0] corr_z;
      logic        divide_fault;
      logic [31:0] max_ratio;
      logic        mesh_skewed;
      logic        pass_done;
   } corr_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [287:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   face_type pending_faces[$];
   corr_type expected_corr[$];
   face_type face_on_bus;
   logic [31:0] model_threshold = SKEW_THRESHOLD_RESET;
   logic [31:0] model_ratio_max = '0;
   int mismatches = 0;
   bit quiet = 1'b0;
   int send_gap = 0;
   int recv_stall = 0;

   skew_correction_vector_unit dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] mag64(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint dot_quarter(logic [2:0][31:0] a, logic [2:0][31:0] b);
      longint acc;
      longint p;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         p = longint'($signed(a[i])) * longint'($signed(b[i]));
         acc += (p < 0) ? -longint'(mag64(p) >> 2) : longint'(mag64(p) >> 2);
      end
      return acc;
   endfunction

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] sum_squares(logic [2:0][31:0] v);
      logic [63:0] acc;
      logic [63:0] m;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
         m = mag64(longint'($signed(v[i])));
         acc += m * m;
      end
      return acc;
   endfunction

   function corr_type predict_correction(face_type f);
      corr_type r;
      longint num;
      longint den;
      longint v;
      logic [63:0] nd;
      logic [63:0] nk;
      logic [63:0] ratio;
      logic [127:0] q;
      logic [2:0][31:0] k;
      bit neg;
      r = '0;
      k = '0;
      if (f.op == OP_INTERIOR || f.op == OP_COUPLED) begin
         num = dot_quarter(f.area, f.offset);
         den = dot_quarter(f.area, f.delta);
         nd = isqrt(sum_squares(f.delta));
         if (den == 0 || nd == 0) begin
            r.divide_fault = 1'b1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               neg = (num < 0) ^ ($signed(f.delta[i]) < 0) ^ (den < 0);
               q = (128'(mag64(num)) * 128'(mag64(longint'($signed(f.delta[i])))))
                   / 128'(mag64(den));
               if (q > (128'd1 << SCALE_CAP_BITS)) q = 128'd1 << SCALE_CAP_BITS;
               v = neg ? longint'($signed(f.offset[i])) + longint'(q)
                       : longint'($signed(f.offset[i])) - longint'(q);
               if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
               if (v < -64'sh80000000) v = -64'sh80000000;
               k[i] = v[31:0];
            end
            if (f.op == OP_INTERIOR) begin
               nk = isqrt(sum_squares(k));
               ratio = (nk << RATIO_FRAC_BITS) / nd;
               if (ratio > 64'hFFFFFFFF) ratio = 64'hFFFFFFFF;
               if (ratio[31:0] > model_ratio_max) model_ratio_max = ratio[31:0];
            end
         end
      end
      r.corr_x = k[0];
      r.corr_y = k[1];
      r.corr_z = k[2];
      r.max_ratio = model_ratio_max;
      r.pass_done = f.last;
      if (f.last) begin
         r.mesh_skewed = model_ratio_max >= model_threshold;
         model_ratio_max = '0;
      end
      return r;
   endfunction

   function automatic int srand_range(int r);
      return int'($urandom_range(0, 2 * r)) - r;
   endfunction

   function automatic face_type random_face();
      face_type f;
      int mode;
      int dd;
      bit exact;
      mode = $urandom_range(0, 9);
      exact = ($urandom_range(0, 3) == 0);
      f.last = ($urandom_range(0, 11) == 0);
      if (mode < 6) begin
         f.op = ($urandom_range(0, 4) == 0) ? OP_COUPLED : OP_INTERIOR;
         for (int i = 0; i < 3; i++) begin
            dd = srand_range(1 << 20);
            f.delta[i] = dd;
            f.offset[i] = (dd >>> 1) + (exact ? 0 : srand_range(256));
            f.area[i] = dd + srand_range(32);
         end
      end else if (mode < 8) begin
         f.op = 2'($urandom_range(0, 3));
         for (int i = 0; i < 3; i++) begin
            f.delta[i] = $urandom;
            f.offset[i] = $urandom;
            f.area[i] = $urandom;
         end
      end else begin
         f.op = 2'($urandom_range(0, 3));
         for (int i = 0; i < 3; i++) begin
            f.delta[i] = srand_range(8);
            f.offset[i] = srand_range(8);
            f.area[i] = srand_range(8);
         end
      end
      return f;
   endfunction

   function automatic face_type make_face(logic [1:0] op, logic last, int ox, int oy, int oz,
                                          int dx, int dy, int dz, int sx, int sy, int sz);
      face_type f;
      f.op = op;
      f.last = last;
      f.offset = {oz, oy, ox};
      f.delta = {dz, dy, dx};
      f.area = {sz, sy, sx};
      return f;
   endfunction

   // stimulus side
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_corr.push_back(predict_correction(face_on_bus));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_faces.size() > 0) begin
               face_on_bus = pending_faces.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {face_on_bus.area, face_on_bus.delta, face_on_bus.offset};
               req_tuser <= face_on_bus.op;
               req_tlast <= face_on_bus.last;
               if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 17);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result side
   always @(posedge clock) begin
      corr_type got;
      corr_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            {got.max_ratio, got.corr_z, got.corr_y, got.corr_x} = rsp_tdata;
            got.divide_fault = rsp_tuser[0];
            got.mesh_skewed = rsp_tuser[1];
            got.pass_done = rsp_tlast;
            if (expected_corr.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transaction: %h", got);
            end else begin
               want = expected_corr.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: corr %h %h %h fault %b max %h skew %b done %b,",
                               " got corr %h %h %h fault %b max %h skew %b done %b"},
                              want.corr_x, want.corr_y, want.corr_z, want.divide_fault,
                              want.max_ratio, want.mesh_skewed, want.pass_done,
                              got.corr_x, got.corr_y, got.corr_z, got.divide_fault,
                              got.max_ratio, got.mesh_skewed, got.pass_done);
               end
            end
         end
      end
      if (recv_stall > 0) begin
         recv_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 17);
      end
   end

   task automatic write_threshold(logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(REG_SKEW_THRESHOLD) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      model_threshold = value;
   endtask

   task automatic drain();
      while (pending_faces.size() > 0 || req_tvalid || expected_corr.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [31:0] thresholds[NUM_PHASES];
      thresholds = '{SKEW_THRESHOLD_RESET, 32'h0, 32'hFFFFFFFF, 32'h0100_0000,
                     $urandom_range(0, 32'h0004_0000), 32'h0000_0001};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      // directed faces: extremes, every kind, divisor corner cases
      pending_faces.push_back(make_face(OP_INTERIOR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_faces.push_back(make_face(OP_INTERIOR, 0, 100, 0, 0, 3, 0, 0, 1, 0, 0));
      pending_faces.push_back(make_face(OP_COUPLED, 0, 5, 5, 5, 0, 0, 0, 7, 7, 7));
      pending_faces.push_back(make_face(OP_INTERIOR, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
      pending_faces.push_back(make_face(OP_INTERIOR, 0, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                              32'h80000000, 32'h80000000, 32'h80000000));
      pending_faces.push_back(make_face(OP_INTERIOR, 0, 32'h7FFFFFFF, 32'h80000000,
                              32'h7FFFFFFF, 4, 32'h7FFFFFFF, 32'h80000000, 4, 0, 0));
      pending_faces.push_back(make_face(OP_COUPLED, 0, 32'h80000000, 32'h7FFFFFFF, 0,
                              32'h80000000, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 0, 4));
      pending_faces.push_back(make_face(OP_INTERIOR, 0, 65536, 0, 0, 131072, 0, 0,
                              65536, 0, 0));
      pending_faces.push_back(make_face(OP_INTERIOR, 1, 65536, 65536, 0, 131072, 0, 0,
                              65536, 0, 0));
      pending_faces.push_back(make_face(OP_UNCOUPLED, 0, 9, 9, 9, 1, 2, 3, 4, 5, 6));
      pending_faces.push_back(make_face(OP_RESERVED, 0, 9, 9, 9, 1, 2, 3, 4, 5, 6));
      pending_faces.push_back(make_face(OP_UNCOUPLED, 1, -1, -1, -1, -1, -1, -1, -1,
                              -1, -1));
      pending_faces.push_back(make_face(OP_INTERIOR, 1, 200, -300, 50, 1000, 0, 0,
                              1000, 0, 0));
      pending_faces.push_back(make_face(OP_RESERVED, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p > 0) write_threshold(thresholds[p]);
         if (p == NUM_PHASES - 1) quiet = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_faces.push_back(random_face());
         drain();
      end
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_corr.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
design/scv_pkg.sv
design/scv_front.sv
design/scv_queue.sv
design/scv_iter.sv
design/scv_back.sv
design/skew_correction_vector_unit.sv
design/scv_checker.sv
tb/sv/skew_correction_vector_unit_test.sv
